### rtl/urom_pkg.sv
// Shared types and constants for the banked program ROM mapper.
// Holds operation codes, command kinds, store widths and the front-to-back command.
// No dependencies.
package urom_pkg;

    // Field widths
    localparam int OP_W   = 3;
    localparam int ADDR_W = 16;
    localparam int LOAD_W = 17;
    localparam int DATA_W = 8;
    localparam int BANK_W = 4;

    // Store geometry
    localparam int PRG_AW  = 17;               // 128 KiB program store
    localparam int OFFS_W  = 14;               // 16 KiB bank
    localparam int BSEL_W  = PRG_AW - OFFS_W;  // bank bits that reach the store
    localparam int PAT_AW  = 13;               // 8 KiB pattern store
    localparam int NT_AW   = 11;               // 2 KiB name-table store
    localparam int TBL_AW  = 10;               // 1 KiB per name table

    // Operation codes
    localparam logic [OP_W-1:0] OP_CPU_RD = 3'd0;
    localparam logic [OP_W-1:0] OP_CPU_WR = 3'd1;
    localparam logic [OP_W-1:0] OP_PPU_RD = 3'd2;
    localparam logic [OP_W-1:0] OP_PPU_WR = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

    // Address map
    localparam logic [ADDR_W-1:0] PPU_TABLE_BASE = 16'h2000;
    localparam logic [ADDR_W-1:0] PPU_TABLE_LAST = 16'h3EFF;
    localparam logic [BANK_W-1:0] BANK_MASK      = 4'hF;

    // What the back end does with one request
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_PRG_RD,
        CMD_PRG_WR,
        CMD_PAT_RD,
        CMD_PAT_WR,
        CMD_NT_RD,
        CMD_NT_WR
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [PRG_AW-1:0]   addr;
        logic [DATA_W-1:0]   data;
    } t_cmd;

endpackage

### rtl/urom_front.sv
// Front end: decodes each accepted request into a store command.
// Holds the bank register and the mirroring register. Depends on urom_pkg.
module urom_front #(
    parameter int PRG_BANKS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [urom_pkg::OP_W-1:0]     i_operation,
    input  logic [urom_pkg::ADDR_W-1:0]   i_address,
    input  logic [urom_pkg::LOAD_W-1:0]   i_load_index,
    input  logic [urom_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    output urom_pkg::t_cmd                o_cmd,
    output logic                          o_cmd_valid
);
    import urom_pkg::*;

    localparam logic [BANK_W-1:0] LAST_BANK = BANK_W'(PRG_BANKS - 1);
    localparam logic [BANK_W:0]   NBANKS    = (BANK_W + 1)'(PRG_BANKS);

    logic [BANK_W-1:0] r_bank;
    logic [BANK_W-1:0] n_bank;
    logic              r_mirror_vertical;
    logic              tbl_sel;
    t_cmd              cmd;

    // Reduce a bank number modulo the bank count by repeated subtraction
    function automatic logic [BANK_W-1:0] bank_wrap(input logic [BANK_W-1:0] v);
        logic [BANK_W:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 8; i++) begin
            if (r >= NBANKS) begin
                r = r - NBANKS;
            end
        end
        return r[BANK_W-1:0];
    endfunction

    // Pick the name table from the mirroring mode
    assign tbl_sel = r_mirror_vertical ? i_address[TBL_AW] : i_address[TBL_AW+1];

    // Classify the request
    always_comb begin
        cmd      = '0;
        cmd.kind = CMD_NONE;
        cmd.data = i_write_data;
        n_bank   = r_bank;
        case (i_operation)
            OP_CPU_RD: begin
                if (i_address[ADDR_W-1:ADDR_W-2] == 2'b10) begin
                    cmd.kind = CMD_PRG_RD;
                    cmd.addr = {r_bank[BSEL_W-1:0], i_address[OFFS_W-1:0]};
                end else if (i_address[ADDR_W-1:ADDR_W-2] == 2'b11) begin
                    cmd.kind = CMD_PRG_RD;
                    cmd.addr = {LAST_BANK[BSEL_W-1:0], i_address[OFFS_W-1:0]};
                end
            end
            OP_CPU_WR: begin
                n_bank = bank_wrap(i_write_data[BANK_W-1:0] & BANK_MASK);
            end
            OP_PPU_RD, OP_PPU_WR: begin
                if (i_address < PPU_TABLE_BASE) begin
                    cmd.kind = (i_operation == OP_PPU_RD) ? CMD_PAT_RD : CMD_PAT_WR;
                    cmd.addr = PRG_AW'(i_address[PAT_AW-1:0]);
                end else if (i_address <= PPU_TABLE_LAST) begin
                    cmd.kind = (i_operation == OP_PPU_RD) ? CMD_NT_RD : CMD_NT_WR;
                    cmd.addr = PRG_AW'({tbl_sel, i_address[TBL_AW-1:0]});
                end
            end
            OP_LOAD: begin
                cmd.kind = CMD_PRG_WR;
                cmd.addr = i_load_index;
            end
            default: begin
                cmd.kind = CMD_NONE;
            end
        endcase
    end

    assign o_cmd       = cmd;
    assign o_cmd_valid = i_accept;

    // Hold the bank and mirroring registers; the bank is stored already wrapped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank            <= '0;
            r_mirror_vertical <= 1'b0;
        end else begin
            if (i_accept) begin
                r_bank <= n_bank;
            end
            if (i_cfg_wr_en) begin
                r_mirror_vertical <= i_cfg_wr_data;
            end
        end
    end

endmodule

### rtl/urom_fifo.sv
// Two-entry command queue between the decode front and the store back end.
// Depends on urom_pkg for the command type.
module urom_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  urom_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output urom_pkg::t_cmd   o_cmd
);
    import urom_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Store an entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### rtl/urom_back.sv
// Back end: carries out store commands on the program, pattern and name-table
// memories and queues the read bytes for the result side. Depends on urom_pkg.
module urom_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  urom_pkg::t_cmd                i_cmd,
    input  logic                          i_cmd_valid,
    output logic                          o_cmd_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [urom_pkg::DATA_W-1:0]   o_read_data
);
    import urom_pkg::*;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;

    logic [DATA_W-1:0] r_prg_mem [2**PRG_AW];
    logic [DATA_W-1:0] r_pat_mem [2**PAT_AW];
    logic [DATA_W-1:0] r_nt_mem  [2**NT_AW];

    logic [DATA_W-1:0] r_prg_q;
    logic [DATA_W-1:0] r_pat_q;
    logic [DATA_W-1:0] r_nt_q;
    t_kind             r_rd_kind;
    logic              r_rd_valid;

    logic [DATA_W-1:0] r_out [OUT_DEPTH];
    logic [OUT_AW-1:0] r_out_wr;
    logic [OUT_AW-1:0] r_out_rd;
    logic [OUT_AW:0]   r_out_cnt;

    logic              issue;
    logic              out_pop;
    logic [DATA_W-1:0] rd_byte;

    // Issue while the result queue has room for everything in flight
    assign issue     = i_cmd_valid && ((r_out_cnt + (OUT_AW + 1)'(r_rd_valid)) < 3'd3);
    assign o_cmd_pop = issue;
    assign out_pop   = i_pop && !o_empty;
    assign o_empty   = (r_out_cnt == '0);
    assign o_read_data = r_out[r_out_rd];

    // Program store access
    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.kind == CMD_PRG_WR) begin
            r_prg_mem[i_cmd.addr] <= i_cmd.data;
        end
        r_prg_q <= r_prg_mem[i_cmd.addr];
    end

    // Pattern store access
    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.kind == CMD_PAT_WR) begin
            r_pat_mem[i_cmd.addr[PAT_AW-1:0]] <= i_cmd.data;
        end
        r_pat_q <= r_pat_mem[i_cmd.addr[PAT_AW-1:0]];
    end

    // Name-table store access
    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.kind == CMD_NT_WR) begin
            r_nt_mem[i_cmd.addr[NT_AW-1:0]] <= i_cmd.data;
        end
        r_nt_q <= r_nt_mem[i_cmd.addr[NT_AW-1:0]];
    end

    // Select the byte that came back; writes and unmapped reads give zero
    always_comb begin
        case (r_rd_kind)
            CMD_PRG_RD: rd_byte = r_prg_q;
            CMD_PAT_RD: rd_byte = r_pat_q;
            CMD_NT_RD:  rd_byte = r_nt_q;
            default:    rd_byte = '0;
        endcase
    end

    // Store a result byte
    always_ff @(posedge i_clk) begin
        if (r_rd_valid) begin
            r_out[r_out_wr] <= rd_byte;
        end
        if (issue) begin
            r_rd_kind <= i_cmd.kind;
        end
    end

    // Track the in-flight read and the result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_out_wr   <= '0;
            r_out_rd   <= '0;
            r_out_cnt  <= '0;
        end else begin
            r_rd_valid <= issue;
            if (r_rd_valid) begin
                r_out_wr <= r_out_wr + 1'b1;
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + 1'b1;
            end
            if (r_rd_valid && !out_pop) begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end else if (out_pop && !r_rd_valid) begin
                r_out_cnt <= r_out_cnt - 1'b1;
            end
        end
    end

    // Result queue never overfills, counting the read in flight
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_cnt + (OUT_AW + 1)'(r_rd_valid)) <= 3'(OUT_DEPTH))
        else $error("result queue overfilled");

    // Every issued command returns exactly one byte in the next cycle
    a_issue_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_rd_valid)
        else $error("issued command lost");

    // A returning byte with no pop grows the queue by one
    a_cnt_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !out_pop) |=> (r_out_cnt == $past(r_out_cnt) + 1'b1))
        else $error("result count out of step");

endmodule

### rtl/banked_rom_mapper_with_mirroring.sv
// Top level of the banked program ROM mapper; depends on urom_pkg, urom_front,
// urom_fifo and urom_back. An accepted request passes through the command queue,
// then the registered store read, then the result queue. Throughput: one request
// per cycle while neither queue stalls it; the single port of each store sets it.
// Reset (synchronous, active low) clears the bank register, the mirroring mode
// and all queues; store contents stay undefined until written.
module banked_rom_mapper_with_mirroring #(
    parameter int PRG_BANKS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [urom_pkg::OP_W-1:0]     i_operation,
    input  logic [urom_pkg::ADDR_W-1:0]   i_address,
    input  logic [urom_pkg::LOAD_W-1:0]   i_load_index,
    input  logic [urom_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [urom_pkg::DATA_W-1:0]   o_read_data
);
    import urom_pkg::*;

    t_cmd front_cmd;
    logic front_valid;
    t_cmd q_cmd;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign accept = push && !full;

    // Decode requests
    urom_front #(
        .PRG_BANKS (PRG_BANKS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_operation   (i_operation),
        .i_address     (i_address),
        .i_load_index  (i_load_index),
        .i_write_data  (i_write_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cmd         (front_cmd),
        .o_cmd_valid   (front_valid)
    );

    // Buffer commands between the two halves
    urom_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    // Execute on the stores
    urom_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_cmd),
        .i_cmd_valid (!q_empty),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_read_data (o_read_data)
    );

endmodule

### bench/tb.sv
// Self-checking bench for the banked program ROM mapper with name-table mirroring.
// Keeps its own image of the bank register, the mirroring mode and all three stores.
// Depends on urom_pkg and banked_rom_mapper_with_mirroring.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urom_pkg::*;

    localparam int PRG_BANKS   = 8;
    localparam int BANK_BYTES  = 1 << OFFS_W;
    localparam int PRG_DEPTH   = 1 << PRG_AW;
    localparam int PAT_DEPTH   = 1 << PAT_AW;
    localparam int NT_DEPTH    = 1 << NT_AW;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 300;

    // Codes the block treats as no operation
    localparam logic [OP_W-1:0] OP_UNDEF_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNDEF_LAST  = 3'd7;

    // CPU address map
    localparam logic [ADDR_W-1:0] PRG_SWITCH_BASE = 16'h8000;
    localparam logic [ADDR_W-1:0] PRG_FIXED_BASE  = 16'hC000;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                push          = 1'b0;
    logic                full;
    logic [OP_W-1:0]     i_operation   = '0;
    logic [ADDR_W-1:0]   i_address     = '0;
    logic [LOAD_W-1:0]   i_load_index  = '0;
    logic [DATA_W-1:0]   i_write_data  = '0;
    logic                i_cfg_wr_en   = 1'b0;
    logic                i_cfg_wr_data = 1'b0;
    logic                empty;
    logic                pop           = 1'b0;
    logic [DATA_W-1:0]   o_read_data;

    // Mapper image kept by the bench
    logic [DATA_W-1:0]   prg_image [PRG_DEPTH];
    bit                  prg_loaded [PRG_DEPTH];
    logic [DATA_W-1:0]   pat_image [PAT_DEPTH];
    bit                  pat_written [PAT_DEPTH];
    logic [DATA_W-1:0]   nt_image [NT_DEPTH];
    bit                  nt_written [NT_DEPTH];
    logic [BANK_W-1:0]   bank_sel        = '0;
    logic                mirror_vertical = 1'b0;

    logic [DATA_W-1:0]   read_data_due [$];
    logic [DATA_W-1:0]   due_byte;
    int                  mismatches    = 0;
    int                  cycle_count   = 0;
    int                  send_idle_pct = 32;
    int                  recv_idle_pct = 78;
    int                  hold_request  = 0;
    int                  hold_left     = 0;

    banked_rom_mapper_with_mirroring #(
        .PRG_BANKS(PRG_BANKS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_address    (i_address),
        .i_load_index (i_load_index),
        .i_write_data (i_write_data),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .empty        (empty),
        .pop          (pop),
        .o_read_data  (o_read_data)
    );

    always #2 i_clk = ~i_clk;

    // Abort a run that hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, read_data_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Program store index for a CPU read: switched window or fixed last bank
    function automatic logic [PRG_AW-1:0] prg_index(input logic [ADDR_W-1:0] addr);
        int unsigned bank;
        bank = (addr < PRG_FIXED_BASE) ? (int'(bank_sel) % PRG_BANKS) : (PRG_BANKS - 1);
        return PRG_AW'((bank * BANK_BYTES + addr[OFFS_W-1:0]) & (PRG_DEPTH - 1));
    endfunction

    // Name-table index: bit 10 picks the table when vertical, bit 11 when horizontal
    function automatic logic [NT_AW-1:0] nt_index(input logic [ADDR_W-1:0] addr);
        logic tbl;
        tbl = mirror_vertical ? addr[TBL_AW] : addr[TBL_AW+1];
        return {tbl, addr[TBL_AW-1:0]};
    endfunction

    // Apply one request to the image and return the byte it reads
    function automatic logic [DATA_W-1:0] mapper_access(
        input logic [OP_W-1:0]   op,
        input logic [ADDR_W-1:0] addr,
        input logic [LOAD_W-1:0] idx,
        input logic [DATA_W-1:0] data
    );
        logic [DATA_W-1:0] rd;
        rd = '0;
        case (op)
            OP_CPU_RD: begin
                if (addr >= PRG_SWITCH_BASE)
                    rd = prg_image[prg_index(addr)];
            end
            OP_CPU_WR: begin
                bank_sel = data[BANK_W-1:0] & BANK_MASK;
            end
            OP_PPU_RD: begin
                if (addr < PPU_TABLE_BASE)
                    rd = pat_image[addr[PAT_AW-1:0]];
                else if (addr <= PPU_TABLE_LAST)
                    rd = nt_image[nt_index(addr)];
            end
            OP_PPU_WR: begin
                if (addr < PPU_TABLE_BASE) begin
                    pat_image[addr[PAT_AW-1:0]]   = data;
                    pat_written[addr[PAT_AW-1:0]] = 1'b1;
                end else if (addr <= PPU_TABLE_LAST) begin
                    nt_image[nt_index(addr)]   = data;
                    nt_written[nt_index(addr)] = 1'b1;
                end
            end
            OP_LOAD: begin
                prg_image[idx]  = data;
                prg_loaded[idx] = 1'b1;
            end
            default: ;
        endcase
        return rd;
    endfunction

    // Offer one request from a falling edge until it is taken, then log its read byte
    task automatic send_request(
        input logic [OP_W-1:0]   op,
        input logic [ADDR_W-1:0] addr,
        input logic [LOAD_W-1:0] idx,
        input logic [DATA_W-1:0] data
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push         <= 1'b1;
        i_operation  <= op;
        i_address    <= addr;
        i_load_index <= idx;
        i_write_data <= data;
        do @(posedge i_clk); while (full);
        read_data_due.push_back(mapper_access(op, addr, idx, data));
        @(negedge i_clk);
    endtask

    // CPU read; load the program byte first if the read would hit an unwritten entry
    task automatic read_prg(input logic [ADDR_W-1:0] addr);
        logic [PRG_AW-1:0] idx;
        if (addr >= PRG_SWITCH_BASE) begin
            idx = prg_index(addr);
            if (!prg_loaded[idx])
                send_request(OP_LOAD, ADDR_W'($urandom), idx, DATA_W'($urandom));
        end
        send_request(OP_CPU_RD, addr, LOAD_W'($urandom), DATA_W'($urandom));
    endtask

    // Video read; write the byte first if the read would hit an unwritten entry
    task automatic read_ppu(input logic [ADDR_W-1:0] addr);
        bit known;
        known = 1'b1;
        if (addr < PPU_TABLE_BASE)
            known = pat_written[addr[PAT_AW-1:0]];
        else if (addr <= PPU_TABLE_LAST)
            known = nt_written[nt_index(addr)];
        if (!known)
            send_request(OP_PPU_WR, addr, LOAD_W'($urandom), DATA_W'($urandom));
        send_request(OP_PPU_RD, addr, LOAD_W'($urandom), DATA_W'($urandom));
    endtask

    // Stop offering requests and wait until every read byte has come back
    task automatic drain();
        push <= 1'b0;
        while (read_data_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write the mirroring register; only called while the block is idle
    task automatic set_mirroring(input logic vertical);
        i_cfg_wr_en     <= 1'b1;
        i_cfg_wr_data   <= vertical;
        mirror_vertical  = vertical;
        @(negedge i_clk);
        i_cfg_wr_en     <= 1'b0;
    endtask

    // Random mix of requests; many addresses fall in a small hot set so reads hit data
    task automatic random_traffic(input int count);
        int                sel;
        logic [ADDR_W-1:0] a;
        logic [LOAD_W-1:0] li;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            a   = ADDR_W'($urandom);
            li  = LOAD_W'($urandom);
            if (sel < 15) begin
                if ($urandom_range(0, 1)) li[OFFS_W-1:6] = '0;
                send_request(OP_LOAD, a, li, DATA_W'($urandom));
            end else if (sel < 25) begin
                send_request(OP_CPU_WR, a, li, DATA_W'($urandom));
            end else if (sel < 50) begin
                a[ADDR_W-1] = 1'b1;
                if ($urandom_range(0, 1)) a[OFFS_W-1:6] = '0;
                read_prg(a);
            end else if (sel < 55) begin
                a[ADDR_W-1] = 1'b0;
                read_prg(a);
            end else if (sel < 92) begin
                if ($urandom_range(0, 9) != 0) a[ADDR_W-1:ADDR_W-2] = '0;
                if ($urandom_range(0, 1)) a[9:4] = '0;
                if (sel < 68)
                    send_request(OP_PPU_WR, a, li, DATA_W'($urandom));
                else
                    read_ppu(a);
            end else begin
                send_request(OP_W'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST)), a, li,
                             DATA_W'($urandom));
            end
        end
    endtask

    // Bank switching, bank folding, fixed bank and unmapped CPU reads
    task automatic test_prg_banks();
        send_request(OP_LOAD, '0, '0, 8'h00);
        send_request(OP_LOAD, '1, '1, 8'hFF);
        read_prg(16'h8000);
        read_prg(16'hFFFF);
        read_prg(16'hC000);
        // bank 15 folds onto bank 7
        send_request(OP_CPU_WR, 16'h0000, '0, 8'hFF);
        read_prg(16'h8000);
        read_prg(16'hBFFF);
        // bank 8 folds onto bank 0
        send_request(OP_CPU_WR, 16'hFFFF, '1, 8'h08);
        read_prg(16'h8000);
        // upper nibble of the data is dropped
        send_request(OP_CPU_WR, 16'h8000, '0, 8'hF3);
        read_prg(16'h9234);
        read_prg(16'h7FFF);
        read_prg(16'h0000);
    endtask

    // Pattern store edges, unmapped video range and undefined operations
    task automatic test_ppu_and_undefined();
        send_request(OP_PPU_WR, 16'h0000, '0, 8'hA5);
        send_request(OP_PPU_WR, 16'h1FFF, '1, 8'h5A);
        send_request(OP_PPU_WR, 16'h3F00, '0, 8'h77);
        read_ppu(16'h0000);
        read_ppu(16'h3F00);
        read_ppu(16'hFFFF);
        for (int k = OP_UNDEF_FIRST; k <= OP_UNDEF_LAST; k++)
            send_request(OP_W'(k), 16'h1FFF, '1, 8'hFF);
        // undefined codes must leave bank and pattern store untouched
        read_ppu(16'h1FFF);
        read_prg(16'h8000);
    endtask

    // Same writes and reads under both mirroring modes
    task automatic test_mirroring();
        for (int m = 1; m >= 0; m--) begin
            drain();
            set_mirroring(m[0]);
            send_request(OP_PPU_WR, 16'h2400, '0, DATA_W'($urandom));
            read_ppu(PPU_TABLE_BASE);
            read_ppu(16'h2C00);
            read_ppu(PPU_TABLE_LAST);
        end
    endtask

    // One random phase with its own idling rates and mirroring mode
    task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
        drain();
        set_mirroring(1'($urandom_range(0, 1)));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        random_traffic(count);
    endtask

    // Hold the reader off long enough that the block fills and stalls the writer
    task automatic test_backpressure();
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        random_traffic(80);
        drain();
        random_traffic(20);
    endtask

    // Reader: random pops, long holds on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Compare each popped byte with the oldest outstanding read
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (read_data_due.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: read_data %02h popped with no request outstanding",
                             $realtime, o_read_data);
                mismatches++;
            end else begin
                due_byte = read_data_due.pop_front();
                if (o_read_data !== due_byte) begin
                    if (mismatches < 10)
                        $display("%0t: read_data expected %02h got %02h",
                                 $realtime, due_byte, o_read_data);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_prg_banks();
        test_ppu_and_undefined();
        test_mirroring();
        test_random_phase(32, 78, 500);
        test_random_phase(78, 32, 500);
        test_random_phase(0, 0, 400);
        test_backpressure();
        drain();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### banked_rom_mapper_with_mirroring.f
rtl/urom_pkg.sv
rtl/urom_front.sv
rtl/urom_fifo.sv
rtl/urom_back.sv
rtl/banked_rom_mapper_with_mirroring.sv
bench/tb.sv
